/* rtl/tgi_pkg.sv */
package tgi_pkg;

   localparam int GRID_DIM_DEFAULT = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS = 8;
   localparam int POS_BITS = 12;
   localparam int IDX_BITS = 4;
   localparam int SIZE_BITS = 4;
   localparam int FACE_BITS = 2;
   localparam int WGT_BITS = POS_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [FACE_BITS-1:0] FACE_NONE = 2'd3;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 4'd15;
   localparam logic CELL_CENTERED_RESET = 1'b1;

   localparam logic [1:0] TAP_LAST = 2'd2;
   localparam logic [1:0] KERN_LAST = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SIZE_X,
      CSR_SIZE_Y,
      CSR_SIZE_Z,
      CSR_CELL_CENTERED
   } csr_index_type;

   typedef enum logic [1:0] {
      LVL_Z,
      LVL_Y,
      LVL_X
   } level_type;

   typedef struct packed {
      logic                          operation;
      logic [IDX_BITS-1:0]           write_x;
      logic [IDX_BITS-1:0]           write_y;
      logic [IDX_BITS-1:0]           write_z;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [POS_BITS-1:0]           pos_x;
      logic [POS_BITS-1:0]           pos_y;
      logic [POS_BITS-1:0]           pos_z;
      logic [FACE_BITS-1:0]          face_axis;
   } req_payload_type;

   typedef struct packed {
      logic        write_sample;
      logic        capture;
      logic        setup;
      logic        rd_en;
      logic [1:0]  rd_i;
      logic [1:0]  rd_j;
      logic [1:0]  rd_k;
      logic        kern_start;
      level_type   kern_level;
      logic        emit;
   } ctl_cmd_type;

endpackage

/* rtl/tgi_if.sv */
interface tgi_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   operation;
   logic [tgi_pkg::IDX_BITS-1:0]           write_x;
   logic [tgi_pkg::IDX_BITS-1:0]           write_y;
   logic [tgi_pkg::IDX_BITS-1:0]           write_z;
   logic signed [tgi_pkg::SAMPLE_BITS-1:0] sample_value;
   logic [tgi_pkg::POS_BITS-1:0]           pos_x;
   logic [tgi_pkg::POS_BITS-1:0]           pos_y;
   logic [tgi_pkg::POS_BITS-1:0]           pos_z;
   logic [tgi_pkg::FACE_BITS-1:0]          face_axis;

   modport source (
      output valid, operation, write_x, write_y, write_z, sample_value,
             pos_x, pos_y, pos_z, face_axis,
      input  ready
   );
   modport sink (
      input  valid, operation, write_x, write_y, write_z, sample_value,
             pos_x, pos_y, pos_z, face_axis,
      output ready
   );
endinterface

interface tgi_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tgi_pkg::SAMPLE_BITS-1:0] result_value;
   logic                                   saturated;

   modport source (output valid, result_value, saturated, input ready);
   modport sink (input valid, result_value, saturated, output ready);
endinterface

interface tgi_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [tgi_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [tgi_pkg::CSR_DATA_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tgi_ctrl.sv */
module tgi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_ready,
   input  logic                 out_free,
   output tgi_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_DRAIN,
      ST_KZ,
      ST_KY,
      ST_KX,
      ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] i_ff, i_in;
   logic [1:0] j_ff, j_in;
   logic [1:0] k_ff, k_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      cmd.rd_i = i_ff;
      cmd.rd_j = j_ff;
      cmd.rd_k = k_ff;
      cmd.kern_level = tgi_pkg::LVL_Z;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == tgi_pkg::OP_QUERY) begin
                  cmd.capture = 1'b1;
                  state_in = ST_SETUP;
               end else begin
                  cmd.write_sample = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            i_in = '0;
            j_in = '0;
            k_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            if (k_ff == tgi_pkg::TAP_LAST) begin
               k_in = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            cnt_in = '0;
            state_in = ST_KZ;
         end
         ST_KZ: begin
            cmd.kern_start = (cnt_ff == '0);
            cmd.kern_level = tgi_pkg::LVL_Z;
            if (cnt_ff == tgi_pkg::KERN_LAST) begin
               cnt_in = '0;
               if (j_ff == tgi_pkg::TAP_LAST) begin
                  j_in = '0;
                  state_in = ST_KY;
               end else begin
                  j_in = j_ff + 2'd1;
                  state_in = ST_READ;
               end
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         ST_KY: begin
            cmd.kern_start = (cnt_ff == '0);
            cmd.kern_level = tgi_pkg::LVL_Y;
            if (cnt_ff == tgi_pkg::KERN_LAST) begin
               cnt_in = '0;
               if (i_ff == tgi_pkg::TAP_LAST) begin
                  i_in = '0;
                  state_in = ST_KX;
               end else begin
                  i_in = i_ff + 2'd1;
                  state_in = ST_READ;
               end
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         ST_KX: begin
            cmd.kern_start = (cnt_ff == '0);
            cmd.kern_level = tgi_pkg::LVL_X;
            if (cnt_ff == tgi_pkg::KERN_LAST) begin
               cnt_in = '0;
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/tgi_datapath.sv */
module tgi_datapath #(
   parameter int GRID_DIM = tgi_pkg::GRID_DIM_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tgi_pkg::req_payload_type req,
   input  tgi_pkg::ctl_cmd_type     cmd,
   output logic                     out_free,
   tgi_csr_if.sink                  csr_chan,
   tgi_rsp_if.source                rsp_chan
);

   localparam int SB = tgi_pkg::SAMPLE_BITS;
   localparam int FB = tgi_pkg::FRAC_BITS;
   localparam int PB = tgi_pkg::POS_BITS;
   localparam int IB = tgi_pkg::IDX_BITS;
   localparam int WB = tgi_pkg::WGT_BITS;
   localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = PB - FB + 3;
   localparam int P_BITS = SB + 2;
   localparam int Q_BITS = SB + 1;
   localparam int MW = P_BITS + WB + 1;
   localparam int PW = MW + WB;

   localparam logic [FB-1:0] HALF = FB'(1) << (FB - 1);
   localparam logic [AW-1:0] G_A = AW'(GRID_DIM);
   localparam logic signed [PW-1:0] ROUND_C = PW'(1) <<< (2 * FB);
   localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (SB - 1)) - PW'(1);
   localparam logic signed [PW-1:0] SAT_LO = -(PW'(1) <<< (SB - 1));

   typedef struct packed {
      logic [IB-1:0]        idx;
      logic signed [WB-1:0] wgt;
   } axis_type;

   function automatic axis_type axis_setup(
      input logic [PB-1:0]                  pos,
      input logic [tgi_pkg::SIZE_BITS-1:0]  size,
      input logic                           on_face,
      input logic [FB-1:0]                  off
   );
      logic [PB:0]          shifted;
      logic signed [CW-1:0] raw_s;
      logic signed [CW-1:0] hi_s;
      logic signed [CW-1:0] idx_s;
      logic [WB-1:0]        diff;
      axis_type             res;
      shifted = {1'b0, pos} + (PB + 1)'(HALF) - (PB + 1)'(off);
      raw_s = $signed(CW'(shifted[PB:FB]));
      hi_s = $signed(CW'(size)) - (on_face ? CW'(1) : CW'(2));
      idx_s = (raw_s > hi_s) ? hi_s : raw_s;
      if (idx_s < $signed(CW'(1))) begin
         idx_s = $signed(CW'(1));
      end
      res.idx = IB'(idx_s);
      diff = WB'(pos) - WB'({res.idx, {FB{1'b0}}}) - WB'(off);
      res.wgt = $signed(diff);
      return res;
   endfunction

   function automatic logic [AW-1:0] lin_addr(
      input logic [IB:0] x,
      input logic [IB:0] y,
      input logic [IB:0] z
   );
      return AW'(x) * G_A * G_A + AW'(y) * G_A + AW'(z);
   endfunction

   // configuration
   logic [tgi_pkg::SIZE_BITS-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic                          cell_centered_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= tgi_pkg::SIZE_RESET;
         size_y_ff <= tgi_pkg::SIZE_RESET;
         size_z_ff <= tgi_pkg::SIZE_RESET;
         cell_centered_ff <= tgi_pkg::CELL_CENTERED_RESET;
      end else if (csr_chan.valid) begin
         unique case (tgi_pkg::csr_index_type'(csr_chan.index))
            tgi_pkg::CSR_SIZE_X: size_x_ff <= csr_chan.data[tgi_pkg::SIZE_BITS-1:0];
            tgi_pkg::CSR_SIZE_Y: size_y_ff <= csr_chan.data[tgi_pkg::SIZE_BITS-1:0];
            tgi_pkg::CSR_SIZE_Z: size_z_ff <= csr_chan.data[tgi_pkg::SIZE_BITS-1:0];
            tgi_pkg::CSR_CELL_CENTERED: cell_centered_ff <= csr_chan.data[0];
         endcase
      end
   end

   // query capture and axis setup
   logic [PB-1:0]                 qpos_x_ff, qpos_y_ff, qpos_z_ff;
   logic [tgi_pkg::FACE_BITS-1:0] qface_ff;
   logic [IB-1:0]                 ix_ff, iy_ff, iz_ff;
   logic signed [WB-1:0]          wx_ff, wy_ff, wz_ff;
   logic [FB-1:0]                 off_x, off_y, off_z, off_other;
   logic                          face_x, face_y, face_z;
   axis_type                      ax_x, ax_y, ax_z;

   always_comb begin
      face_x = (qface_ff == tgi_pkg::FACE_BITS'(0));
      face_y = (qface_ff == tgi_pkg::FACE_BITS'(1));
      face_z = (qface_ff == tgi_pkg::FACE_BITS'(2));
      if (qface_ff == tgi_pkg::FACE_NONE) begin
         off_other = cell_centered_ff ? HALF : '0;
      end else begin
         off_other = HALF;
      end
      off_x = face_x ? '0 : off_other;
      off_y = face_y ? '0 : off_other;
      off_z = face_z ? '0 : off_other;
      ax_x = axis_setup(qpos_x_ff, size_x_ff, face_x, off_x);
      ax_y = axis_setup(qpos_y_ff, size_y_ff, face_y, off_y);
      ax_z = axis_setup(qpos_z_ff, size_z_ff, face_z, off_z);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qpos_x_ff <= req.pos_x;
         qpos_y_ff <= req.pos_y;
         qpos_z_ff <= req.pos_z;
         qface_ff <= req.face_axis;
      end
      if (cmd.setup) begin
         ix_ff <= ax_x.idx;
         iy_ff <= ax_y.idx;
         iz_ff <= ax_z.idx;
         wx_ff <= ax_x.wgt;
         wy_ff <= ax_y.wgt;
         wz_ff <= ax_z.wgt;
      end
   end

   // sample store
   logic signed [SB-1:0] store_mem [DEPTH];
   logic [IB:0]          wr_x, wr_y, wr_z;
   logic [IB:0]          rd_x, rd_y, rd_z;
   logic                 wr_en;
   logic                 rd_oor;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic signed [SB-1:0] rd_data_ff;
   logic                 rd_oor_ff;
   logic                 rd_pend_ff;

   always_comb begin
      wr_x = (IB + 1)'(req.write_x);
      wr_y = (IB + 1)'(req.write_y);
      wr_z = (IB + 1)'(req.write_z);
      wr_en = cmd.write_sample && (int'(wr_x) < GRID_DIM) && (int'(wr_y) < GRID_DIM)
              && (int'(wr_z) < GRID_DIM);
      wr_addr = lin_addr(wr_x, wr_y, wr_z);
      rd_x = (IB + 1)'(ix_ff) + (IB + 1)'(cmd.rd_i) - (IB + 1)'(1);
      rd_y = (IB + 1)'(iy_ff) + (IB + 1)'(cmd.rd_j) - (IB + 1)'(1);
      rd_z = (IB + 1)'(iz_ff) + (IB + 1)'(cmd.rd_k) - (IB + 1)'(1);
      rd_oor = (int'(rd_x) >= GRID_DIM) || (int'(rd_y) >= GRID_DIM)
               || (int'(rd_z) >= GRID_DIM);
      rd_addr = lin_addr(rd_x, rd_y, rd_z);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req.sample_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
         rd_oor_ff <= rd_oor;
      end
   end

   // stencil rows
   logic signed [SB-1:0] samp_ff [3];
   logic signed [SB-1:0] ys_ff [3];
   logic signed [SB-1:0] xs_ff [3];
   logic signed [SB-1:0] final_ff;
   logic                 clip_ff;

   // kernel pipeline
   logic signed [SB-1:0]     a0, a1, a2;
   logic signed [WB-1:0]     wsel;
   logic signed [P_BITS-1:0] p_val;
   logic signed [Q_BITS-1:0] q_val;
   logic signed [MW-1:0]     pw_val;
   logic signed [MW-1:0]     m_in, m_ff;
   logic signed [WB-1:0]     w1_ff;
   logic signed [SB-1:0]     x1_1_ff, x1_2_ff;
   tgi_pkg::level_type       lvl1_ff, lvl2_ff;
   logic                     v1_ff, v2_ff;
   logic signed [PW-1:0]     mw_val;
   logic signed [PW-1:0]     prod_in, prod_ff;
   logic signed [PW-1:0]     sh_val, sum_val;
   logic signed [SB-1:0]     kres;
   logic                     kclip;

   always_comb begin
      case (cmd.kern_level)
         tgi_pkg::LVL_Y: begin
            a0 = ys_ff[0];
            a1 = ys_ff[1];
            a2 = ys_ff[2];
            wsel = wy_ff;
         end
         tgi_pkg::LVL_X: begin
            a0 = xs_ff[0];
            a1 = xs_ff[1];
            a2 = xs_ff[2];
            wsel = wx_ff;
         end
         default: begin
            a0 = samp_ff[0];
            a1 = samp_ff[1];
            a2 = samp_ff[2];
            wsel = wz_ff;
         end
      endcase
      p_val = P_BITS'(a0) + P_BITS'(a2) - (P_BITS'(a1) <<< 1);
      q_val = Q_BITS'(a2) - Q_BITS'(a0);
      pw_val = p_val * wsel;
      m_in = pw_val + (MW'(q_val) <<< FB);
      mw_val = m_ff * w1_ff;
      prod_in = mw_val + ROUND_C;
      sh_val = prod_ff >>> (2 * FB + 1);
      sum_val = sh_val + PW'(x1_2_ff);
      kclip = 1'b0;
      if (sum_val > SAT_HI) begin
         kres = SB'(SAT_HI);
         kclip = 1'b1;
      end else if (sum_val < SAT_LO) begin
         kres = SB'(SAT_LO);
         kclip = 1'b1;
      end else begin
         kres = SB'(sum_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
         v1_ff <= cmd.kern_start;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         samp_ff[0] <= samp_ff[1];
         samp_ff[1] <= samp_ff[2];
         samp_ff[2] <= rd_oor_ff ? '0 : rd_data_ff;
      end
      if (cmd.kern_start) begin
         m_ff <= m_in;
         w1_ff <= wsel;
         x1_1_ff <= a1;
         lvl1_ff <= cmd.kern_level;
      end
      if (v1_ff) begin
         prod_ff <= prod_in;
         x1_2_ff <= x1_1_ff;
         lvl2_ff <= lvl1_ff;
      end
      if (cmd.setup) begin
         clip_ff <= 1'b0;
      end else if (v2_ff) begin
         clip_ff <= clip_ff | kclip;
      end
      if (v2_ff) begin
         case (lvl2_ff)
            tgi_pkg::LVL_Z: begin
               ys_ff[0] <= ys_ff[1];
               ys_ff[1] <= ys_ff[2];
               ys_ff[2] <= kres;
            end
            tgi_pkg::LVL_Y: begin
               xs_ff[0] <= xs_ff[1];
               xs_ff[1] <= xs_ff[2];
               xs_ff[2] <= kres;
            end
            tgi_pkg::LVL_X: final_ff <= kres;
            default: ;
         endcase
      end
   end

   // result register
   logic                 rsp_valid_ff;
   logic signed [SB-1:0] rsp_value_ff;
   logic                 rsp_sat_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= final_ff;
         rsp_sat_ff <= clip_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

endmodule

/* rtl/triquadratic_grid_interpolator_unit.sv */
// triquadratic grid interpolator
// req_chan carries requests: operation 0 writes sample_value into the grid
// store at (write_x, write_y, write_z); operation 1 queries the value at
// (pos_x, pos_y, pos_z) with 8 fraction bits, face_axis selecting the layout.
// rsp_chan returns one result_value and saturated flag per query, none per
// write. csr_chan writes size_x, size_y, size_z and cell_centered at index
// 0 to 3; it is always ready and is meant to be used while the block is idle.
// writes are taken one per cycle while no query is in progress. a query walks
// its 3x3x3 stencil through the single read port of the store, three reads per
// z row, and runs its 13 quadratic kernels one after another through a
// three-stage multiply unit. no new request is taken until the query has
// handed its result to the output register.
// the result waits in an output register; while the receiver stalls the block
// still takes new requests, and a finished query holds until that register
// is free. synchronous reset returns to idle, empties the output register and
// restores the size registers to 15 and cell_centered to 1; the store is not
// cleared and must be written before it is read.
module triquadratic_grid_interpolator_unit #(
   parameter int GRID_DIM = tgi_pkg::GRID_DIM_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   tgi_req_if.sink   req_chan,
   tgi_rsp_if.source rsp_chan,
   tgi_csr_if.sink   csr_chan
);

   tgi_pkg::req_payload_type req_payload;
   tgi_pkg::ctl_cmd_type     cmd;
   logic                     out_free;
   logic                     ready;

   always_comb begin
      req_payload.operation = req_chan.operation;
      req_payload.write_x = req_chan.write_x;
      req_payload.write_y = req_chan.write_y;
      req_payload.write_z = req_chan.write_z;
      req_payload.sample_value = req_chan.sample_value;
      req_payload.pos_x = req_chan.pos_x;
      req_payload.pos_y = req_chan.pos_y;
      req_payload.pos_z = req_chan.pos_z;
      req_payload.face_axis = req_chan.face_axis;
   end

   assign req_chan.ready = ready;

   tgi_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (ready),
      .out_free      (out_free),
      .cmd           (cmd)
   );

   tgi_datapath #(
      .GRID_DIM (GRID_DIM)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req      (req_payload),
      .cmd      (cmd),
      .out_free (out_free),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
